### design/isq_pkg.sv
// shared constants for the inverse square root mod 2^k block
package isq_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int DATA_BITS     = 64;
    localparam int CFG_BITS      = 7;
    localparam int LIMB_BITS     = 32;
    localparam int CNT_BITS      = 8;

    localparam logic [CFG_BITS-1:0] BIT_COUNT_RST = CFG_BITS'(64);
    localparam logic [CFG_BITS-1:0] MIN_BIT_COUNT = CFG_BITS'(3);
    localparam logic [CNT_BITS-1:0] FIRST_BIT     = CNT_BITS'(2);

endpackage

### design/isq_ifs.sv
// valid/ready channels of the inverse square root block
interface isq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [isq_pkg::CFG_BITS-1:0]  bit_count;

    modport source (output valid, output bit_count, input ready);
    modport sink   (input valid, input bit_count, output ready);
endinterface

interface isq_in_if;
    logic                          valid;
    logic                          ready;
    logic [isq_pkg::DATA_BITS-1:0] square_value;

    modport source (output valid, output square_value, input ready);
    modport sink   (input valid, input square_value, output ready);
endinterface

interface isq_out_if;
    logic                          valid;
    logic                          ready;
    logic [isq_pkg::DATA_BITS-1:0] inv_root;

    modport source (output valid, output inv_root, input ready);
    modport sink   (input valid, input inv_root, output ready);
endinterface

### design/inverse_sqrt_mod_pow2.sv
// inverse square root modulo 2^k on one shared 32x32 multiplier
// one item at a time; L = ceil(WORD_BITS/32) limbs, each wide product built from limb products
// n = min(k-1, WORD_BITS) - 2 rounds (none below k = 3), each two products, plus one final product when k-1 < WORD_BITS
// the input is not ready until the result is placed in the output register
// synchronous active-low reset: bit_count returns to 64, the sequencer idles, no result pending
module inverse_sqrt_mod_pow2 #(
    parameter int WORD_BITS = isq_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isq_cfg_if.sink   i_cfg,
    isq_in_if.sink    i_in,
    isq_out_if.source o_out
);

    localparam int LB       = isq_pkg::LIMB_BITS;
    localparam int LB_LOG   = $clog2(LB);
    localparam int LIMBS    = (WORD_BITS + LB - 1) / LB;
    localparam int PAD_BITS = LIMBS * LB;
    localparam int LIMB_IDX = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int BIT_IDX  = $clog2(WORD_BITS);
    localparam int CB       = isq_pkg::CNT_BITS;
    localparam int KB       = isq_pkg::CFG_BITS;
    localparam int DB       = isq_pkg::DATA_BITS;

    localparam logic [CB-1:0]       WORD_LIM  = CB'(WORD_BITS);
    localparam logic [LIMB_IDX-1:0] LAST_LIMB = LIMB_IDX'(LIMBS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            r_state;
    logic [KB-1:0]         r_bit_count;
    logic [WORD_BITS-1:0]  r_e;
    logic [WORD_BITS-1:0]  r_root;
    logic [WORD_BITS-1:0]  r_inv;
    logic [CB-1:0]         r_j;
    logic                  r_phase;
    logic                  r_final;
    logic [LIMB_IDX-1:0]   r_la;
    logic [LIMB_IDX-1:0]   r_lb;
    logic [LIMB_IDX-1:0]   r_sh;
    logic [2*LB-1:0]       r_prod;
    logic [PAD_BITS-1:0]   r_acc;
    logic [DB-1:0]         r_out;
    logic                  r_out_valid;

    logic [WORD_BITS-1:0]  n_root;
    logic [WORD_BITS-1:0]  n_inv;
    logic [CB-1:0]         n_j;

    logic [KB-1:0]         w_last;
    logic [CB-1:0]         w_last_c;
    logic                  w_in_xfer;
    logic [PAD_BITS-1:0]   w_x_pad;
    logic [PAD_BITS-1:0]   w_y_pad;
    logic [LB-1:0]         w_x_limb;
    logic [LB-1:0]         w_y_limb;
    logic [LIMB_IDX-1:0]   w_sum;
    logic [WORD_BITS-1:0]  w_prod_w;
    logic [WORD_BITS-1:0]  w_t;
    logic [CB-1:0]         w_idx;
    logic                  w_bit;
    logic [WORD_BITS-1:0]  w_set;
    logic                  w_loop_first;
    logic                  w_loop_next;
    logic                  w_fin_go;

    assign i_cfg.ready    = 1'b1;
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.inv_root = r_out;
    assign w_in_xfer      = i_in.valid && i_in.ready;

    assign w_last   = (r_bit_count >= isq_pkg::MIN_BIT_COUNT) ? r_bit_count - KB'(1) : KB'(2);
    assign w_last_c = CB'(w_last);
    assign w_fin_go = (w_last_c < WORD_LIM);

    assign w_loop_first = (isq_pkg::FIRST_BIT < w_last_c) && (isq_pkg::FIRST_BIT < WORD_LIM);
    assign n_j          = r_j + CB'(1);
    assign w_loop_next  = (n_j < w_last_c) && (n_j < WORD_LIM);

    // limb selection for the shared multiplier
    assign w_x_pad  = PAD_BITS'(r_root);
    assign w_y_pad  = r_phase ? PAD_BITS'(r_inv) : PAD_BITS'(r_root);
    assign w_x_limb = w_x_pad[{r_la, {LB_LOG{1'b0}}} +: LB];
    assign w_y_limb = w_y_pad[{r_lb, {LB_LOG{1'b0}}} +: LB];
    assign w_sum    = r_la + r_lb;

    // bit extraction from the wrapped difference
    assign w_prod_w = r_acc[WORD_BITS-1:0];
    assign w_t      = r_phase ? (WORD_BITS'(1) - w_prod_w) : (r_e - w_prod_w);
    assign w_idx    = r_phase ? r_j : n_j;
    assign w_bit    = (w_idx < WORD_LIM) ? w_t[w_idx[BIT_IDX-1:0]] : 1'b0;
    assign w_set    = WORD_BITS'(w_bit) << r_j[BIT_IDX-1:0];
    assign n_root   = r_root | w_set;
    assign n_inv    = r_inv | w_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= isq_pkg::BIT_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_bit_count <= i_cfg.bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_e    <= WORD_BITS'(i_in.square_value);
                        r_root <= WORD_BITS'(1);
                        r_inv  <= WORD_BITS'(1);
                        r_j    <= isq_pkg::FIRST_BIT;
                        r_la   <= '0;
                        r_lb   <= '0;
                        r_acc  <= '0;
                        priority if (w_loop_first) begin
                            r_phase <= 1'b0;
                            r_final <= 1'b0;
                            r_state <= S_MUL;
                        end else if (w_fin_go) begin
                            r_j     <= w_last_c;
                            r_phase <= 1'b1;
                            r_final <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= (2*LB)'(w_x_limb) * (2*LB)'(w_y_limb);
                    r_sh    <= w_sum;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + (PAD_BITS'(r_prod) << {r_sh, {LB_LOG{1'b0}}});
                    if (w_sum == LAST_LIMB) begin
                        if (r_la == LAST_LIMB) begin
                            r_state <= S_UPD;
                        end else begin
                            r_la    <= r_la + LIMB_IDX'(1);
                            r_lb    <= '0;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_lb    <= r_lb + LIMB_IDX'(1);
                        r_state <= S_MUL;
                    end
                end
                S_UPD: begin
                    r_la  <= '0;
                    r_lb  <= '0;
                    r_acc <= '0;
                    priority if (!r_phase) begin
                        r_root  <= n_root;
                        r_phase <= 1'b1;
                        r_state <= S_MUL;
                    end else if (r_final) begin
                        r_inv   <= n_inv;
                        r_state <= S_FIN;
                    end else begin
                        r_inv <= n_inv;
                        priority if (w_loop_next) begin
                            r_j     <= n_j;
                            r_phase <= 1'b0;
                            r_state <= S_MUL;
                        end else if (w_fin_go) begin
                            r_j     <= w_last_c;
                            r_final <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out   <= DB'(r_inv);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/isq_checker.sv
// port-level assertions for the inverse square root block, with its bind
module isq_props (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [isq_pkg::DATA_BITS-1:0] i_out_data
);

    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_pend = r_pend;
        if (w_in_xfer && !w_out_xfer) begin
            n_pend = r_pend + 2'd1;
        end else if (w_out_xfer && !w_in_xfer) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    // busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // no result without an accepted item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without a pending item");

    // at most one item in work and one result waiting
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many items outstanding");

endmodule

bind inverse_sqrt_mod_pow2 isq_props u_isq_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.inv_root)
);
